### hdl/aeskx_pkg.sv
// aeskx_pkg: shared types, state encoding, s-box and round constants
// for the aes-128 key expansion unit; no dependencies
`default_nettype none

package aeskx_pkg;

    localparam int unsigned RoundKeys = 11;
    localparam int unsigned RoundW    = 4;
    localparam logic [RoundW-1:0] LastRound = RoundW'(RoundKeys - 1);

    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
    } t_key_word;

    typedef struct packed {
        logic [63:0]       round_key_high;
        logic [63:0]       round_key_low;
        logic [RoundW-1:0] round_number;
        logic              last_round;
    } t_round_word;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } t_kx_state;

    typedef struct packed {
        logic load;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
    } t_dp_stat;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) begin
            r[i*8 +: 8] = SBOX[w[i*8 +: 8]];
        end
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [RoundW-1:0] rnd);
        logic [7:0] r;
        unique case (rnd)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/aes128_key_expansion_unit.sv
// aes128_key_expansion_unit: top level of the aes-128 key schedule generator
// depends on aeskx_pkg, aeskx_ctrl, aeskx_dp
//
//   channel  | handshake         | word
//   ---------+-------------------+------------------------------------------
//   key in   | start, busy       | i_key   (key_high, key_low)
//   round out| o_valid strobe    | o_round (round keys, number, last flag)
//
// a key is taken when start is high and busy low; its eleven round keys
// leave on consecutive cycles, one per cycle, from the round key register.
// busy drops during the last round word, so the next key can load then and follow with no gap.
// the round key register and its one-round update path set the pace of the round words.
// synchronous active-low reset returns the controller to idle.
// the receiver cannot stall: each round word shows for one cycle only.
`default_nettype none

module aes128_key_expansion_unit (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    input  wire aeskx_pkg::t_key_word   i_key,
    output logic                        busy,
    output logic                        o_valid,
    output aeskx_pkg::t_round_word      o_round
);

    aeskx_pkg::t_dp_cmd  cmd;
    aeskx_pkg::t_dp_stat stat;

    aeskx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    aeskx_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_key   (i_key),
        .o_stat  (stat),
        .o_round (o_round)
    );

endmodule

`default_nettype wire

### hdl/aeskx_ctrl.sv
// aeskx_ctrl: controller for the key expansion unit, sequences the eleven rounds
// depends on aeskx_pkg
`default_nettype none

module aeskx_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire aeskx_pkg::t_dp_stat i_stat,
    output aeskx_pkg::t_dp_cmd      o_cmd,
    output logic                    o_busy,
    output logic                    o_valid
);

    aeskx_pkg::t_kx_state r_state;
    aeskx_pkg::t_kx_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aeskx_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        o_busy        = 1'b0;
        o_valid       = 1'b0;
        unique case (r_state)
            aeskx_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = aeskx_pkg::ST_RUN;
                end
            end
            aeskx_pkg::ST_RUN: begin
                o_valid = 1'b1;
                if (i_stat.last) begin
                    // last word goes out while the next key may load
                    if (i_start) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        n_state = aeskx_pkg::ST_IDLE;
                    end
                end else begin
                    o_busy        = 1'b1;
                    o_cmd.advance = 1'b1;
                end
            end
            default: begin
                n_state = aeskx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/aeskx_dp.sv
// aeskx_dp: datapath holding the current round key and round counter
// depends on aeskx_pkg (s-box, round constants, word types)
`default_nettype none

module aeskx_dp (
    input  wire logic                   i_clk,
    input  wire aeskx_pkg::t_dp_cmd     i_cmd,
    input  wire aeskx_pkg::t_key_word   i_key,
    output aeskx_pkg::t_dp_stat         o_stat,
    output aeskx_pkg::t_round_word      o_round
);

    logic [127:0]                    r_key;
    logic [aeskx_pkg::RoundW-1:0]    r_round;
    logic [127:0]                    n_key;
    logic [31:0]                     w0, w1, w2, w3, t, k0, k1, k2, k3;

    always_comb begin
        w0 = r_key[127:96];
        w1 = r_key[95:64];
        w2 = r_key[63:32];
        w3 = r_key[31:0];
        t  = aeskx_pkg::sub_word({w3[23:0], w3[31:24]})
             ^ {aeskx_pkg::rcon(r_round), 24'h000000};
        k0 = w0 ^ t;
        k1 = w1 ^ k0;
        k2 = w2 ^ k1;
        k3 = w3 ^ k2;
        n_key = {k0, k1, k2, k3};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key   <= {i_key.key_high, i_key.key_low};
            r_round <= '0;
        end else if (i_cmd.advance) begin
            r_key   <= n_key;
            r_round <= r_round + aeskx_pkg::RoundW'(1);
        end
    end

    assign o_stat.last            = (r_round == aeskx_pkg::LastRound);
    assign o_round.round_key_high = r_key[127:64];
    assign o_round.round_key_low  = r_key[63:0];
    assign o_round.round_number   = r_round;
    assign o_round.last_round     = (r_round == aeskx_pkg::LastRound);

endmodule

`default_nettype wire
